// ===== hw/rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared widths, byte tag codes and the decode result type.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned CntW  = 3;   // results per byte, 0..4
  localparam int unsigned NeedW = 2;

  // Byte class tags (top bits of the byte)
  localparam logic [1:0] ContTag  = 2'b10;    // 10xxxxxx
  localparam logic [2:0] Lead2Tag = 3'b110;   // 110xxxxx, one continuation
  localparam logic [3:0] Lead3Tag = 4'b1110;  // 1110xxxx, two continuations
  localparam logic [4:0] Lead4Tag = 5'b11110; // 11110xxx, three continuations

  localparam logic [CntW-1:0]  CntZero  = '0;
  localparam logic [CntW-1:0]  CntOne   = CntW'(1);
  localparam logic [NeedW-1:0] NeedNone = '0;

  // One decoded byte: cnt results, all malformed zero but the last, which
  // carries cp / bad.
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [CpW-1:0]  cp;
    logic            bad;
  } dec_res_t;

endpackage

// ===== hw/rtl/utf8d_if.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder channels
// Valid/ready byte input channel and code point result channel.
// ----------------------------------------------------------------------------
interface utf8d_in_if;
  logic                         valid;
  logic                         ready;
  logic [utf8d_pkg::ByteW-1:0]  text_byte;
  logic                         end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utf8d_out_if;
  logic                       valid;
  logic                       ready;
  logic [utf8d_pkg::CpW-1:0]  code_point;
  logic                       malformed;
  logic                       last_of_run;

  modport source (output valid, output code_point, output malformed,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input malformed,
                  input last_of_run, output ready);
endinterface

// ===== hw/rtl/utf8_code_point_decoder_core.sv =====
// ----------------------------------------------------------------------------
// UTF-8 code point decoder core
// A byte beat accepted into the input register is decoded into the result
//   register once that register is free; its first result beat is offered from then on.
// Throughput: one byte per cycle while result beats are taken and each byte gives
//   at most one result; a byte with n results holds the result register for n beats.
// Reset (rst_ni, async, low): sequence state cleared, no beat held.
// Streaming decoder: bytes in, one beat per code point or skipped byte out.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  utf8d_in_if.sink    in_i,
  utf8d_out_if.source out_o
);

  logic                        s1_valid;
  logic [utf8d_pkg::ByteW-1:0] s1_byte;
  logic                        s1_eot;
  logic                        load_ok;
  logic                        advance;
  utf8d_pkg::dec_res_t         dec_res;

  // Byte moves from the input register into decode/result register when the
  // result register is empty or hands out its final beat this cycle.
  assign advance = s1_valid && load_ok;

  utf8d_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .byte_o    (s1_byte),
    .eot_o     (s1_eot)
  );

  // Sequence state updates on the same edge the result is registered.
  utf8d_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (s1_byte),
    .eot_i     (s1_eot),
    .res_o     (dec_res)
  );

  // A byte with zero results loads a zero count: nothing is offered.
  utf8d_out_seq u_out_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance),
    .res_i     (dec_res),
    .load_ok_o (load_ok),
    .out_o     (out_o)
  );

endmodule

// ===== hw/rtl/utf8d_in_reg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder input register
// Holds one accepted byte beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module utf8d_in_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  utf8d_in_if.sink                    in_i,
  input  logic                        advance_i,
  output logic                        valid_o,
  output logic [utf8d_pkg::ByteW-1:0] byte_o,
  output logic                        eot_o
);

  logic                        valid_q;
  logic [utf8d_pkg::ByteW-1:0] byte_q;
  logic                        eot_q;

  assign in_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.text_byte;
      eot_q  <= in_i.end_of_text;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign eot_o   = eot_q;

endmodule

// ===== hw/rtl/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder step logic
// Sequence state and the one-pass decode of a byte into a result count
// and final result.
// ----------------------------------------------------------------------------
module utf8d_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [utf8d_pkg::ByteW-1:0] byte_i,
  input  logic                        eot_i,
  output utf8d_pkg::dec_res_t         res_o
);

  logic [utf8d_pkg::NeedW-1:0] need_q, need_d;
  logic [utf8d_pkg::NeedW-1:0] taken_q, taken_d;
  logic [utf8d_pkg::CpW-1:0]   part_q, part_d;

  // fresh-byte decode
  logic                        f_res;    // fresh byte gives a result
  logic [utf8d_pkg::CpW-1:0]   f_cp;
  logic                        f_bad;
  logic [utf8d_pkg::NeedW-1:0] f_need;
  logic [utf8d_pkg::CpW-1:0]   f_part;

  logic                        is_cont;
  logic [utf8d_pkg::NeedW-1:0] need_dec;
  logic [utf8d_pkg::NeedW-1:0] taken_inc;
  logic [utf8d_pkg::CpW-1:0]   part_sh;

  always_comb begin
    f_res  = 1'b1;
    f_cp   = '0;
    f_bad  = 1'b1;
    f_need = utf8d_pkg::NeedNone;
    f_part = '0;
    if (!byte_i[7]) begin
      f_cp  = utf8d_pkg::CpW'(byte_i);
      f_bad = 1'b0;
    end else if (byte_i[7:5] == utf8d_pkg::Lead2Tag) begin
      f_need = 2'd1;
      f_part = utf8d_pkg::CpW'(byte_i[4:0]);
    end else if (byte_i[7:4] == utf8d_pkg::Lead3Tag) begin
      f_need = 2'd2;
      f_part = utf8d_pkg::CpW'(byte_i[3:0]);
    end else if (byte_i[7:3] == utf8d_pkg::Lead4Tag) begin
      f_need = 2'd3;
      f_part = utf8d_pkg::CpW'(byte_i[2:0]);
    end
    // a lead opens a sequence: no result unless the text ends here
    if (f_need != utf8d_pkg::NeedNone) begin
      f_res = eot_i;
    end
  end

  assign is_cont   = (byte_i[7:6] == utf8d_pkg::ContTag);
  assign need_dec  = need_q - 2'd1;
  assign taken_inc = taken_q + 2'd1;
  assign part_sh   = {part_q[utf8d_pkg::CpW-7:0], byte_i[5:0]};

  always_comb begin
    res_o   = '{cnt: utf8d_pkg::CntZero, cp: '0, bad: 1'b1};
    need_d  = f_need;
    taken_d = '0;
    part_d  = f_part;
    if (need_q == utf8d_pkg::NeedNone) begin
      res_o.cnt = f_res ? utf8d_pkg::CntOne : utf8d_pkg::CntZero;
      res_o.cp  = f_cp;
      res_o.bad = f_bad;
    end else if (is_cont) begin
      need_d  = need_dec;
      taken_d = taken_inc;
      part_d  = part_sh;
      if (need_dec == utf8d_pkg::NeedNone) begin
        res_o.cnt = utf8d_pkg::CntOne;
        res_o.cp  = part_sh;
        res_o.bad = 1'b0;
      end else if (eot_i) begin
        // cut-off: lead plus every continuation taken
        res_o.cnt = utf8d_pkg::CntOne + utf8d_pkg::CntW'(taken_inc);
      end
    end else begin
      // broken sequence, then the byte is decoded afresh
      res_o.cnt = utf8d_pkg::CntOne + utf8d_pkg::CntW'(taken_q)
                + utf8d_pkg::CntW'(f_res);
      if (f_res) begin
        res_o.cp  = f_cp;
        res_o.bad = f_bad;
      end
    end
    if (eot_i) begin
      need_d  = utf8d_pkg::NeedNone;
      taken_d = '0;
      part_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q  <= utf8d_pkg::NeedNone;
      taken_q <= '0;
      part_q  <= '0;
    end else if (advance_i) begin
      need_q  <= need_d;
      taken_q <= taken_d;
      part_q  <= part_d;
    end
  end

endmodule

// ===== hw/rtl/utf8d_out_seq.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder result sequencer
// Result register that plays out the beats of one decoded byte.
// ----------------------------------------------------------------------------
module utf8d_out_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  utf8d_pkg::dec_res_t res_i,
  output logic                load_ok_o,
  utf8d_out_if.source         out_o
);

  logic [utf8d_pkg::CntW-1:0] cnt_q;   // beats left
  logic [utf8d_pkg::CpW-1:0]  cp_q;
  logic                       bad_q;
  logic                       final_beat;

  assign final_beat  = (cnt_q == utf8d_pkg::CntOne);
  assign load_ok_o   = (cnt_q == utf8d_pkg::CntZero) || (final_beat && out_o.ready);

  assign out_o.valid       = (cnt_q != utf8d_pkg::CntZero);
  assign out_o.code_point  = final_beat ? cp_q : '0;
  assign out_o.malformed   = final_beat ? bad_q : 1'b1;
  assign out_o.last_of_run = final_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= utf8d_pkg::CntZero;
    end else if (load_i) begin
      cnt_q <= res_i.cnt;
    end else if (out_o.valid && out_o.ready) begin
      cnt_q <= cnt_q - utf8d_pkg::CntOne;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cp_q  <= res_i.cp;
      bad_q <= res_i.bad;
    end
  end

endmodule

// ===== dv/utf8_cp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 code point checker
// Watches the byte and result channels of the decoder, predicts the result
// beats of every accepted byte and compares each accepted result beat with
// the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_cp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  utf8d_in_if         in_mon,
  utf8d_out_if        out_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned MaxBeats = 4;

  typedef struct packed {
    logic [utf8d_pkg::CpW-1:0] cp;
    logic                      bad;
    logic                      last;
  } cp_beat_t;

  // sequence state of the predicted decoder
  logic [utf8d_pkg::NeedW-1:0] need_q;
  logic [1:0]                  taken_q;
  logic [utf8d_pkg::CpW-1:0]   acc_q;

  cp_beat_t byte_beats_q[$];  // beats of the byte being decoded
  cp_beat_t cp_expect_q[$];   // beats still owed by the block

  function automatic void clear_seq();
    need_q  = utf8d_pkg::NeedNone;
    taken_q = '0;
    acc_q   = '0;
  endfunction

  function automatic void emit_beat(input logic [utf8d_pkg::CpW-1:0] cp,
                                    input logic                      bad);
    if (byte_beats_q.size() < MaxBeats) begin
      byte_beats_q.push_back('{cp: cp, bad: bad, last: 1'b0});
    end
  endfunction

  // lead plus every continuation taken so far become malformed beats
  function automatic void drop_seq();
    emit_beat('0, 1'b1);
    for (int k = 0; k < int'(taken_q); k++) begin
      emit_beat('0, 1'b1);
    end
    clear_seq();
  endfunction

  function automatic void open_byte(input logic [utf8d_pkg::ByteW-1:0] b,
                                    input logic                        eot);
    if (!b[7]) begin
      emit_beat(utf8d_pkg::CpW'(b), 1'b0);
      return;
    end
    if (b[7:5] == utf8d_pkg::Lead2Tag) begin
      need_q = utf8d_pkg::NeedW'(1);
      acc_q  = utf8d_pkg::CpW'(b[4:0]);
    end else if (b[7:4] == utf8d_pkg::Lead3Tag) begin
      need_q = utf8d_pkg::NeedW'(2);
      acc_q  = utf8d_pkg::CpW'(b[3:0]);
    end else if (b[7:3] == utf8d_pkg::Lead4Tag) begin
      need_q = utf8d_pkg::NeedW'(3);
      acc_q  = utf8d_pkg::CpW'(b[2:0]);
    end else begin
      emit_beat('0, 1'b1);
      return;
    end
    taken_q = '0;
    if (eot) drop_seq();
  endfunction

  function automatic void decode_byte(input logic [utf8d_pkg::ByteW-1:0] b,
                                      input logic                        eot);
    byte_beats_q.delete();
    if (need_q != utf8d_pkg::NeedNone) begin
      if (b[7:6] == utf8d_pkg::ContTag) begin
        acc_q   = {acc_q[utf8d_pkg::CpW-7:0], b[5:0]};
        taken_q = taken_q + 2'd1;
        need_q  = need_q - utf8d_pkg::NeedW'(1);
        if (need_q == utf8d_pkg::NeedNone) begin
          emit_beat(acc_q, 1'b0);
          clear_seq();
        end else if (eot) begin
          drop_seq();
        end
      end else begin
        drop_seq();
        open_byte(b, eot);
      end
    end else begin
      open_byte(b, eot);
    end
    if (eot) clear_seq();
    if (byte_beats_q.size() > 0) byte_beats_q[byte_beats_q.size()-1].last = 1'b1;
    foreach (byte_beats_q[i]) cp_expect_q.push_back(byte_beats_q[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cp_beat_t got, want;
    if (!rst_ni) begin
      clear_seq();
      cp_expect_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        decode_byte(in_mon.text_byte, in_mon.end_of_text);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{cp: out_mon.code_point, bad: out_mon.malformed,
                last: out_mon.last_of_run};
        if (cp_expect_q.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: unexpected result beat cp=%06h malformed=%b last=%b",
                   $time, got.cp, got.bad, got.last);
        end else begin
          want = cp_expect_q.pop_front();
          if (got !== want) begin
            fail_cnt_o++;
            $display("%0t: mismatch exp cp=%06h bad=%b last=%b got cp=%06h bad=%b last=%b",
                     $time, want.cp, want.bad, want.last, got.cp, got.bad, got.last);
          end
        end
      end
      pending_o = cp_expect_q.size();
    end
  end

endmodule

// ===== dv/utf8_code_point_decoder_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 code point decoder core testbench
// Feeds byte streams (corner cases first, then random well-formed, broken,
// cut-off and junk runs) with random gaps and output stalls, including one
// long output hold-off. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder_core_tb;

  localparam int unsigned NumBytes   = 330;
  localparam int unsigned StallLimit = 2000; // cycles with no beat on either side
  localparam int unsigned HoldCycles = 64;   // long output hold-off
  localparam int unsigned DrainCyc   = 10;   // tail after the last expected beat
  localparam int unsigned QuietFrom  = 280;  // no idling past this many bytes
  localparam int unsigned PressureAt = 120;

  // bit 8 of a corner entry marks the last byte of a text
  localparam logic [8:0] EotFlag = 9'h100;

  logic clk_i = 1'b0;
  logic rst_ni;

  utf8d_in_if  byte_if ();
  utf8d_out_if cp_if ();

  int unsigned fail_cnt;
  int unsigned pending;

  // Run bookkeeping
  int unsigned n_sent;
  int unsigned n_texts;
  int unsigned n_beats;
  int unsigned n_bad;
  int unsigned quiet_cnt;
  bit          idle_en;   // random gaps on both sides
  bit          hold_req;  // asks the result side for one long hold-off

  // Corner bytes: extremes, every sequence length, invalid leads, a broken
  // sequence and cut-off sequences. The F0 80 80 / C3+eot pair makes one byte
  // give the full four beats (three dropped plus the cut-off fresh lead).
  logic [8:0] corner_bytes [$] = '{
    9'h000, 9'h07F,                       // NUL and top ASCII
    9'h0C2, 9'h0A9,                       // two-byte form
    9'h0E2, 9'h082, 9'h0AC,               // three-byte form
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,       // largest four-byte value
    9'h080, 9'h0FF,                       // stray continuation, invalid lead
    9'h0F0, 9'h080, 9'h080, EotFlag | 9'h0C3,
    9'h0E2, 9'h041,                       // broken by plain ASCII
    9'h0F8,                               // invalid lead
    9'h0E2, EotFlag | 9'h082,             // cut off after a continuation
    EotFlag | 9'h07F                      // end of text on ASCII
  };

  utf8_code_point_decoder_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (cp_if)
  );

  utf8_cp_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (byte_if),
    .out_mon    (cp_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: ready moves at the falling edge. Random stall bursts while
  // idling is on; a hold request turns into one long stall so the block fills
  // up and has to push back on the byte side.
  initial begin
    int unsigned stall_left;
    cp_if.ready = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        cp_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles - 1;
        cp_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        cp_if.ready <= 1'b0;
      end else begin
        cp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog plus beat statistics, sampled at the rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cnt = 0;
    end else begin
      if (cp_if.valid && cp_if.ready) begin
        n_beats++;
        if (cp_if.malformed) n_bad++;
      end
      if ((byte_if.valid && byte_if.ready) || (cp_if.valid && cp_if.ready)) begin
        quiet_cnt = 0;
      end else begin
        quiet_cnt++;
        if (quiet_cnt >= StallLimit) begin
          $display("%0t: timeout, no beat for %0d cycles, %0d results outstanding",
                   $time, quiet_cnt, pending);
          $display("[utf8_code_point_decoder_core] ERROR");
          $finish;
        end
      end
    end
  end

  // One byte beat: optional gap, then hold valid until ready at a rising
  // edge. Returns at the following falling edge.
  task automatic send_byte(input logic [utf8d_pkg::ByteW-1:0] b, input logic eot);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    byte_if.valid       <= 1'b1;
    byte_if.text_byte   <= b;
    byte_if.end_of_text <= eot;
    do @(posedge clk_i); while (!byte_if.ready);
    n_sent++;
    if (eot) n_texts++;
    @(negedge clk_i);
  endtask

  // One random run: mostly well-formed code points with random payload,
  // the rest broken sequences, cut-off sequences and junk bytes.
  task automatic send_random_run();
    logic [utf8d_pkg::ByteW-1:0] run_q[$];
    logic [utf8d_pkg::ByteW-1:0] b;
    int unsigned                 kind;
    int unsigned                 n_cont;
    int unsigned                 n_taken;
    logic                        eot_last;
    kind     = $urandom_range(0, 9);
    n_cont   = $urandom_range(1, 3);
    eot_last = ($urandom_range(0, 7) == 0);
    // lead for a sequence of n_cont continuations
    case (n_cont)
      1:       b = {utf8d_pkg::Lead2Tag, 5'($urandom)};
      2:       b = {utf8d_pkg::Lead3Tag, 4'($urandom)};
      default: b = {utf8d_pkg::Lead4Tag, 3'($urandom)};
    endcase
    case (kind)
      0, 1, 2: begin // ASCII
        run_q.push_back({1'b0, 7'($urandom)});
      end
      3, 4, 5, 6: begin // complete multi-byte code point
        run_q.push_back(b);
        repeat (n_cont) run_q.push_back({utf8d_pkg::ContTag, 6'($urandom)});
      end
      7: begin // broken: too few continuations, then a non-continuation
        run_q.push_back(b);
        n_taken = $urandom_range(0, n_cont - 1);
        repeat (n_taken) run_q.push_back({utf8d_pkg::ContTag, 6'($urandom)});
        do b = 8'($urandom); while (b[7:6] == utf8d_pkg::ContTag);
        run_q.push_back(b);
      end
      8: begin // cut off by end of text
        run_q.push_back(b);
        n_taken = $urandom_range(0, n_cont - 1);
        repeat (n_taken) run_q.push_back({utf8d_pkg::ContTag, 6'($urandom)});
        eot_last = 1'b1;
      end
      default: begin // junk: stray continuation, invalid lead or any byte at all
        case ($urandom_range(0, 2))
          0:       run_q.push_back({utf8d_pkg::ContTag, 6'($urandom)});
          1:       run_q.push_back({5'b11111, 3'($urandom)});
          default: run_q.push_back(8'($urandom));
        endcase
      end
    endcase
    foreach (run_q[i]) begin
      send_byte(run_q[i], eot_last && (i == run_q.size() - 1));
    end
  endtask

  initial begin
    bit pressure_done;
    rst_ni              = 1'b0;
    byte_if.valid       = 1'b0;
    byte_if.text_byte   = '0;
    byte_if.end_of_text = 1'b0;
    idle_en             = 1'b1;
    hold_req            = 1'b0;
    pressure_done       = 1'b0;
    n_sent              = 0;
    n_texts             = 0;
    n_beats             = 0;
    n_bad               = 0;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (corner_bytes[i]) begin
      send_byte(corner_bytes[i][utf8d_pkg::ByteW-1:0], corner_bytes[i][8]);
    end

    while (n_sent < NumBytes) begin
      if (!pressure_done && n_sent >= PressureAt) begin
        // long result stall while bytes keep coming
        hold_req      = 1'b1;
        pressure_done = 1'b1;
      end
      if (n_sent >= QuietFrom) idle_en = 1'b0;
      send_random_run();
    end
    byte_if.valid <= 1'b0;

    // drain: every predicted beat must come out, then a short tail
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCyc) @(negedge clk_i);

    $display("Sent %0d bytes in %0d texts, checked %0d result beats (%0d malformed).",
             n_sent, n_texts, n_beats, n_bad);
    $display("Corners, random well-formed/broken/cut-off/junk runs, gaps and a long stall.");
    if (fail_cnt == 0) begin
      $display("[utf8_code_point_decoder_core] OK");
    end else begin
      $display("[utf8_code_point_decoder_core] ERROR");
    end
    $finish;
  end

endmodule
